// File: src/playfair_digraph_cipher_macros.svh
// ----------------------------------------------------------------------------
// Playfair digraph cipher assertion macros
// Shared property forms for the cipher's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PDC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("playfair cipher check failed");

// Next-cycle implication, disabled during reset
`define PDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("playfair cipher check failed");

`endif

// File: src/pdc_pkg.sv
// ----------------------------------------------------------------------------
// Playfair digraph cipher package
// Types, codes, constants and grid arithmetic shared by the cipher modules.
// ----------------------------------------------------------------------------
package pdc_pkg;

   localparam int LETTER_W    = 5;
   localparam int NUM_LETTERS = 26;
   localparam int GRID_CELLS  = 25;
   localparam int GRID_SIDE   = 5;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [LETTER_W-1:0] LETTER_I    = 5'd8;
   localparam logic [LETTER_W-1:0] LETTER_J    = 5'd9;
   localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(NUM_LETTERS - 1);
   localparam logic [LETTER_W-1:0] PAD_RESET   = 5'd23;
   localparam logic [2:0]          ENC_SHIFT   = 3'd1;
   localparam logic [2:0]          DEC_SHIFT   = 3'd4;

   // Register index of the pad letter (upper paddr bit selects the word)
   localparam logic CSR_INDEX_PAD = 1'b0;

   // Used marks after reset: only J, which shares the cell of I
   localparam logic [NUM_LETTERS-1:0] USED_RESET =
      {{(NUM_LETTERS-1){1'b0}}, 1'b1} << LETTER_J;

   typedef enum logic [1:0] {
      MODE_KEY,
      MODE_ENCRYPT,
      MODE_DECRYPT,
      MODE_END
   } mode_type;

   typedef struct packed {
      mode_type            mode;
      logic [LETTER_W-1:0] letter;
   } req_item_type;

   typedef struct packed {
      logic [LETTER_W-1:0] plain_first;
      logic [LETTER_W-1:0] plain_second;
      logic [LETTER_W-1:0] out_first;
      logic [LETTER_W-1:0] out_second;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_PAIR,
      ST_CELL,
      ST_LOAD
   } ctrl_state_type;

   typedef struct packed {
      logic latch;
      logic fill_step;
      logic pair;
      logic lookup;
      logic load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_fill;
      logic fill_last;
      logic pair_emit;
      logic out_free;
   } dp_status_type;

   // Fold J onto I
   function automatic logic [LETTER_W-1:0] fold_letter(logic [LETTER_W-1:0] v);
      return (v == LETTER_J) ? LETTER_I : v;
   endfunction

   // Row of a grid cell number
   function automatic logic [2:0] place_row(logic [LETTER_W-1:0] p);
      logic [2:0] row;
      row = 3'd0;
      for (int i = 1; i < GRID_SIDE; i++) begin
         if (p >= LETTER_W'(i * GRID_SIDE)) begin
            row = 3'(i);
         end
      end
      return row;
   endfunction

   // Column of a grid cell number
   function automatic logic [2:0] place_col(logic [LETTER_W-1:0] p);
      logic [2:0]          row;
      logic [LETTER_W-1:0] base;
      logic [LETTER_W-1:0] diff;
      row  = place_row(p);
      base = LETTER_W'(row) * LETTER_W'(GRID_SIDE);
      diff = p - base;
      return diff[2:0];
   endfunction

   // Step a row or column forward, wrapping around the grid side
   function automatic logic [2:0] wrap_add(logic [2:0] c, logic [2:0] s);
      logic [3:0] sum;
      sum = {1'b0, c} + {1'b0, s};
      if (sum >= 4'(GRID_SIDE)) begin
         sum = sum - 4'(GRID_SIDE);
      end
      return sum[2:0];
   endfunction

   // Cell number from row and column
   function automatic logic [LETTER_W-1:0] cell_index(logic [2:0] row, logic [2:0] col);
      return LETTER_W'(row) * LETTER_W'(GRID_SIDE) + LETTER_W'(col);
   endfunction

endpackage

// File: src/pdc_csr.sv
// ----------------------------------------------------------------------------
// Playfair cipher register port
// APB-style access to the pad letter register; always ready.
// ----------------------------------------------------------------------------
module pdc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [pdc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [pdc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [pdc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output logic [pdc_pkg::LETTER_W-1:0]   pad_letter
);
   import pdc_pkg::*;

   logic [LETTER_W-1:0] pad_ff;
   logic [LETTER_W-1:0] pad_in;
   logic                pad_sel;

   // Decode the register word
   assign pad_sel = (paddr[CSR_ADDR_W-1] == CSR_INDEX_PAD);

   // Take a write transaction in the access phase
   always_comb begin
      pad_in = pad_ff;
      if (psel && penable && pwrite && pad_sel) begin
         pad_in = pwdata[LETTER_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_ff <= PAD_RESET;
      end else begin
         pad_ff <= pad_in;
      end
   end

   // Return the register on reads, zero elsewhere
   assign prdata     = pad_sel ? {{(CSR_DATA_W-LETTER_W){1'b0}}, pad_ff} : '0;
   assign pready     = 1'b1;
   assign pad_letter = pad_ff;

endmodule

// File: src/pdc_ctrl.sv
// ----------------------------------------------------------------------------
// Playfair cipher controller
// Sequences grid completion, pairing, grid lookups and result loading.
// ----------------------------------------------------------------------------
module pdc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pdc_pkg::dp_status_type status,
   output pdc_pkg::ctrl_cmd_type  cmd
);
   import pdc_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.need_fill ? ST_FILL : ST_PAIR;
            end
         end
         ST_FILL: begin
            if (status.fill_last) begin
               state_in = ST_PAIR;
            end
         end
         ST_PAIR: begin
            state_in = status.pair_emit ? ST_CELL : ST_IDLE;
         end
         ST_CELL: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands to the datapath
   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = req_valid;
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
         end
         ST_PAIR: begin
            cmd.pair = 1'b1;
         end
         ST_CELL: begin
            cmd.lookup = 1'b1;
         end
         ST_LOAD: begin
            cmd.load = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// File: src/pdc_datapath.sv
// ----------------------------------------------------------------------------
// Playfair cipher datapath
// Key grid and letter place memories, used marks, pairing state, the
// substitution lookup and the result register.
// ----------------------------------------------------------------------------
module pdc_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  pdc_pkg::req_item_type         req_item,
   input  logic [pdc_pkg::LETTER_W-1:0]  pad_letter,
   input  pdc_pkg::ctrl_cmd_type         cmd,
   input  logic                          rsp_ready,
   output pdc_pkg::dp_status_type        status,
   output logic                          rsp_valid,
   output pdc_pkg::rsp_item_type         rsp_item
);
   import pdc_pkg::*;

   // Memories: cell -> letter and letter -> cell
   logic [LETTER_W-1:0] grid_mem  [GRID_CELLS];
   logic [LETTER_W-1:0] place_mem [NUM_LETTERS];

   // Latched item
   mode_type            item_mode_ff;
   logic [LETTER_W-1:0] item_letter_ff;
   logic                item_ok_ff;

   // Key and pairing state
   logic [LETTER_W-1:0]    walk_ff, walk_in;
   logic [NUM_LETTERS-1:0] used_ff, used_in;
   logic [LETTER_W-1:0]    fill_ff, fill_in;
   logic                   ready_ff, ready_in;
   logic [LETTER_W-1:0]    held_letter_ff, held_letter_in;
   logic                   held_valid_ff, held_valid_in;
   logic                   held_dec_ff, held_dec_in;

   // Pair under lookup
   logic [LETTER_W-1:0] pair_a_ff, pair_b_ff;
   logic                pair_dec_ff;
   logic [LETTER_W-1:0] pa_ff, pb_ff;
   logic [LETTER_W-1:0] g1_ff, g2_ff;

   // Result register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;

   // Combinational helpers
   logic [LETTER_W-1:0]    pad_fold;
   logic                   item_dec;
   logic [NUM_LETTERS-1:0] key_used;
   logic [LETTER_W-1:0]    key_fill;
   logic                   mem_we;
   logic [LETTER_W-1:0]    mem_cell;
   logic [LETTER_W-1:0]    mem_letter;
   logic                   emit;
   logic [LETTER_W-1:0]    emit_a, emit_b;
   logic                   emit_dec;
   logic [2:0]             r1, c1, r2, c2, shift;
   logic [LETTER_W-1:0]    idx1, idx2;

   // Clamp the pad to Z and fold J
   assign pad_fold = (pad_letter > LAST_LETTER) ? LAST_LETTER : fold_letter(pad_letter);
   assign item_dec = (item_mode_ff == MODE_DECRYPT);

   // Key update, grid completion and pairing
   always_comb begin
      walk_in        = walk_ff;
      used_in        = used_ff;
      fill_in        = fill_ff;
      ready_in       = ready_ff;
      held_letter_in = held_letter_ff;
      held_valid_in  = held_valid_ff;
      held_dec_in    = held_dec_ff;
      key_used       = ready_ff ? USED_RESET : used_ff;
      key_fill       = ready_ff ? '0 : fill_ff;
      mem_we         = 1'b0;
      mem_cell       = fill_ff;
      mem_letter     = walk_ff;
      emit           = 1'b0;
      emit_a         = held_letter_ff;
      emit_b         = pad_fold;
      emit_dec       = held_dec_ff;

      if (cmd.latch) begin
         walk_in = '0;
      end

      // Place the next unused letter of the alphabet walk
      if (cmd.fill_step) begin
         walk_in = walk_ff + 5'd1;
         if (!used_ff[walk_ff] && (fill_ff < LETTER_W'(GRID_CELLS))) begin
            mem_we           = 1'b1;
            mem_cell         = fill_ff;
            mem_letter       = walk_ff;
            used_in[walk_ff] = 1'b1;
            fill_in          = fill_ff + 5'd1;
         end
         if (walk_ff == LAST_LETTER) begin
            ready_in = 1'b1;
         end
      end

      if (cmd.pair) begin
         unique case (item_mode_ff) inside
            MODE_END: begin
               // Close a lone held letter with the pad
               if (held_valid_ff) begin
                  emit          = 1'b1;
                  held_valid_in = 1'b0;
               end
            end
            MODE_KEY: begin
               if (item_ok_ff) begin
                  // Start a fresh key once text has begun
                  if (ready_ff) begin
                     ready_in       = 1'b0;
                     held_letter_in = '0;
                     held_valid_in  = 1'b0;
                     held_dec_in    = 1'b0;
                  end
                  used_in = key_used;
                  fill_in = key_fill;
                  if (!key_used[item_letter_ff] && (key_fill < LETTER_W'(GRID_CELLS))) begin
                     mem_we                  = 1'b1;
                     mem_cell                = key_fill;
                     mem_letter              = item_letter_ff;
                     used_in[item_letter_ff] = 1'b1;
                     fill_in                 = key_fill + 5'd1;
                  end
               end
            end
            MODE_ENCRYPT, MODE_DECRYPT: begin
               if (item_ok_ff) begin
                  if (!held_valid_ff) begin
                     held_letter_in = item_letter_ff;
                     held_valid_in  = 1'b1;
                     held_dec_in    = item_dec;
                  end else if (held_dec_ff != item_dec) begin
                     // Mode change: close the held letter, hold the new one
                     emit           = 1'b1;
                     held_letter_in = item_letter_ff;
                     held_dec_in    = item_dec;
                  end else if (!item_dec && (held_letter_ff == item_letter_ff)) begin
                     // Doubled encrypt letter: pad it and keep holding
                     emit = 1'b1;
                  end else begin
                     emit          = 1'b1;
                     emit_b        = item_letter_ff;
                     held_valid_in = 1'b0;
                  end
               end
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
   end

   // Substitution cells from the two grid places
   always_comb begin
      r1    = place_row(pa_ff);
      c1    = place_col(pa_ff);
      r2    = place_row(pb_ff);
      c2    = place_col(pb_ff);
      shift = pair_dec_ff ? DEC_SHIFT : ENC_SHIFT;
      if (r1 == r2) begin
         idx1 = cell_index(r1, wrap_add(c1, shift));
         idx2 = cell_index(r2, wrap_add(c2, shift));
      end else if (c1 == c2) begin
         idx1 = cell_index(wrap_add(r1, shift), c1);
         idx2 = cell_index(wrap_add(r2, shift), c2);
      end else begin
         idx1 = cell_index(r1, c2);
         idx2 = cell_index(r2, c1);
      end
   end

   // Result register handoff
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff        <= '0;
         used_ff        <= USED_RESET;
         fill_ff        <= '0;
         ready_ff       <= 1'b0;
         held_letter_ff <= '0;
         held_valid_ff  <= 1'b0;
         held_dec_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         walk_ff        <= walk_in;
         used_ff        <= used_in;
         fill_ff        <= fill_in;
         ready_ff       <= ready_in;
         held_letter_ff <= held_letter_in;
         held_valid_ff  <= held_valid_in;
         held_dec_ff    <= held_dec_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         item_mode_ff   <= req_item.mode;
         item_letter_ff <= fold_letter(req_item.letter);
         item_ok_ff     <= (req_item.letter <= LAST_LETTER);
      end
      if (cmd.pair && emit) begin
         pair_a_ff   <= emit_a;
         pair_b_ff   <= emit_b;
         pair_dec_ff <= emit_dec;
      end
      if (cmd.load) begin
         rsp_item_ff.plain_first  <= pair_a_ff;
         rsp_item_ff.plain_second <= pair_b_ff;
         rsp_item_ff.out_first    <= g1_ff;
         rsp_item_ff.out_second   <= g2_ff;
      end
   end

   // Memories: one write port, two registered read ports each
   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_cell]    <= mem_letter;
         place_mem[mem_letter] <= mem_cell;
      end
      if (cmd.pair && emit) begin
         pa_ff <= place_mem[emit_a];
         pb_ff <= place_mem[emit_b];
      end
      if (cmd.lookup) begin
         g1_ff <= grid_mem[idx1];
         g2_ff <= grid_mem[idx2];
      end
   end

   // Status to the controller
   assign status.need_fill = ((req_item.mode == MODE_ENCRYPT) ||
                              (req_item.mode == MODE_DECRYPT)) &&
                             (req_item.letter <= LAST_LETTER) && !ready_ff;
   assign status.fill_last = (walk_ff == LAST_LETTER);
   assign status.pair_emit = emit;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// File: src/playfair_digraph_cipher.sv
// Flow: an accepted item is latched and then paired; a closed digraph goes on through
// the place read, the grid read and the result load, which waits for a free result.
// A new item is taken only once the last one is through; the first text letter after
// a key first runs the alphabet walk that completes the grid.
// Reset: synchronous; clears the key, pairing and result state and sets the pad to X.
// The grid memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// Playfair digraph cipher
// Builds a 5x5 key grid from key letters and substitutes encrypt or decrypt
// digraphs, one result transaction per completed pair.
// ----------------------------------------------------------------------------
`include "playfair_digraph_cipher_macros.svh"

module playfair_digraph_cipher (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  pdc_pkg::req_item_type          req_item,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output pdc_pkg::rsp_item_type          rsp_item,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [pdc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [pdc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [pdc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import pdc_pkg::*;

   logic [LETTER_W-1:0] pad_letter;
   ctrl_cmd_type        ctrl_cmd;
   dp_status_type       dp_status;

   pdc_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .pad_letter (pad_letter)
   );

   pdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   pdc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .pad_letter (pad_letter),
      .cmd        (ctrl_cmd),
      .rsp_ready  (rsp_ready),
      .status     (dp_status),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item)
   );

   // Busy in the cycle after each accepted transaction
   `PDC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // Never overwrite a result that has not been taken
   `PDC_ASSERT_SAME(a_load_when_free, clock, reset, ctrl_cmd.load, !rsp_valid || rsp_ready)
   // A closed pair always moves on to the grid lookup
   `PDC_ASSERT_NEXT(a_pair_to_lookup, clock, reset, ctrl_cmd.pair && dp_status.pair_emit, ctrl_cmd.lookup)
   // A result appears only from a load
   `PDC_ASSERT_SAME(a_valid_from_load, clock, reset, $rose(rsp_valid), $past(ctrl_cmd.load))

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Playfair digraph cipher testbench
// Drives key, encrypt, decrypt and end transactions into the cipher, keeps a
// private copy of the key grid and pairing state to predict each digraph, and
// compares every result transaction in order. Runs a directed table first,
// then random phases under several pad letters with random gaps on both sides
// and one long result stall.
// ----------------------------------------------------------------------------
module tb;
   import pdc_pkg::*;

   localparam int PERIOD          = 12;
   localparam int RESET_CYCLES    = 7;
   localparam int DRAIN_CYCLES    = 40;
   localparam int CYCLE_LIMIT     = 300000;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 64;
   localparam int HOLD_CYCLES     = 400;
   localparam int MAX_REPORTS     = 10;

   localparam logic [CSR_ADDR_W-1:0] PAD_ADDR = CSR_ADDR_W'({CSR_INDEX_PAD, 2'b00});

   // Letter indexes used by the directed table
   localparam logic [LETTER_W-1:0] LT_A = 5'd0;
   localparam logic [LETTER_W-1:0] LT_B = 5'd1;
   localparam logic [LETTER_W-1:0] LT_C = 5'd2;
   localparam logic [LETTER_W-1:0] LT_E = 5'd4;
   localparam logic [LETTER_W-1:0] LT_F = 5'd5;
   localparam logic [LETTER_W-1:0] LT_I = 5'd8;
   localparam logic [LETTER_W-1:0] LT_J = 5'd9;
   localparam logic [LETTER_W-1:0] LT_K = 5'd10;
   localparam logic [LETTER_W-1:0] LT_L = 5'd11;
   localparam logic [LETTER_W-1:0] LT_S = 5'd18;
   localparam logic [LETTER_W-1:0] LT_U = 5'd20;
   localparam logic [LETTER_W-1:0] LT_V = 5'd21;
   localparam logic [LETTER_W-1:0] LT_W = 5'd22;
   localparam logic [LETTER_W-1:0] LT_X = 5'd23;
   localparam logic [LETTER_W-1:0] LT_Y = 5'd24;
   localparam logic [LETTER_W-1:0] LT_Z = 5'd25;

   typedef struct packed {
      req_item_type item;
      bit           fixed_on;
      rsp_item_type fixed;
   } stim_row_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_item_type          req_item  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_item_type          rsp_item;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Predicted cipher state
   logic [LETTER_W-1:0] grid_letter [GRID_CELLS];
   logic [LETTER_W-1:0] letter_pos  [NUM_LETTERS];
   bit                  letter_taken[NUM_LETTERS];
   int                  cells_filled;
   bit                  grid_complete;
   logic [LETTER_W-1:0] pend_letter;
   bit                  pend_valid;
   bit                  pend_decrypt;
   logic [LETTER_W-1:0] pad_reg;

   rsp_item_type        expected_digraphs[$];
   stim_row_type        directed_rows[$];
   rsp_item_type        next_digraph;

   // Random stream state
   mode_type            text_mode;
   logic [LETTER_W-1:0] last_text;
   int                  key_left;

   bit                  tx_quiet;
   bit                  rx_quiet;
   bit                  hold_armed;
   logic                rx_hold = 1'b0;
   int                  rx_wait;
   int                  mismatch_count = 0;
   int                  cycle_count = 0;

   playfair_digraph_cipher u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #(PERIOD / 2) clock = ~clock;

   // Drop the key, the used marks and any held letter
   function automatic void clear_key_grid();
      for (int k = 0; k < GRID_CELLS; k++) begin
         grid_letter[k] = '0;
      end
      for (int k = 0; k < NUM_LETTERS; k++) begin
         letter_pos[k]   = '0;
         letter_taken[k] = (k == LETTER_J);
      end
      cells_filled  = 0;
      grid_complete = 1'b0;
      pend_letter   = '0;
      pend_valid    = 1'b0;
      pend_decrypt  = 1'b0;
   endfunction

   // Append a letter to the grid unless it is already there or the grid is full
   function automatic void place_key_letter(input logic [LETTER_W-1:0] v);
      if (letter_taken[v] || cells_filled >= GRID_CELLS) begin
         return;
      end
      letter_taken[v]           = 1'b1;
      grid_letter[cells_filled] = v;
      letter_pos[v]             = LETTER_W'(cells_filled);
      cells_filled++;
   endfunction

   // Pad in effect: clamp above Z, fold J onto I
   function automatic logic [LETTER_W-1:0] pad_choice();
      logic [LETTER_W-1:0] p;
      p = (pad_reg > LAST_LETTER) ? LAST_LETTER : pad_reg;
      return (p == LETTER_J) ? LETTER_I : p;
   endfunction

   // Substitute one digraph by the row, column or rectangle rule
   function automatic rsp_item_type substitute(input logic [LETTER_W-1:0] a,
                                               input logic [LETTER_W-1:0] b,
                                               input bit dec);
      rsp_item_type r;
      int shift, pa, pb, ra, ca, rb, cb;
      shift = dec ? int'(DEC_SHIFT) : int'(ENC_SHIFT);
      pa = int'(letter_pos[a]);
      pb = int'(letter_pos[b]);
      ra = pa / GRID_SIDE;
      ca = pa % GRID_SIDE;
      rb = pb / GRID_SIDE;
      cb = pb % GRID_SIDE;
      r.plain_first  = a;
      r.plain_second = b;
      if (ra == rb) begin
         r.out_first  = grid_letter[ra * GRID_SIDE + (ca + shift) % GRID_SIDE];
         r.out_second = grid_letter[rb * GRID_SIDE + (cb + shift) % GRID_SIDE];
      end else if (ca == cb) begin
         r.out_first  = grid_letter[((ra + shift) % GRID_SIDE) * GRID_SIDE + ca];
         r.out_second = grid_letter[((rb + shift) % GRID_SIDE) * GRID_SIDE + cb];
      end else begin
         r.out_first  = grid_letter[ra * GRID_SIDE + cb];
         r.out_second = grid_letter[rb * GRID_SIDE + ca];
      end
      return r;
   endfunction

   // Advance the predicted state by one transaction; return 1 when a digraph results
   function automatic bit cipher_step(input req_item_type it, output rsp_item_type res);
      logic [LETTER_W-1:0] v;
      bit                  dec;
      res = '0;
      if (it.mode == MODE_END) begin
         if (!pend_valid) begin
            return 1'b0;
         end
         pend_valid = 1'b0;
         res = substitute(pend_letter, pad_choice(), pend_decrypt);
         return 1'b1;
      end
      if (it.letter >= NUM_LETTERS) begin
         return 1'b0;
      end
      v = (it.letter == LETTER_J) ? LETTER_I : it.letter;
      if (it.mode == MODE_KEY) begin
         if (grid_complete) begin
            clear_key_grid();
         end
         place_key_letter(v);
         return 1'b0;
      end
      dec = (it.mode == MODE_DECRYPT);
      // Complete the grid with the unused letters on the first text letter
      if (!grid_complete) begin
         for (int k = 0; k < NUM_LETTERS; k++) begin
            place_key_letter(LETTER_W'(k));
         end
         grid_complete = 1'b1;
      end
      if (!pend_valid) begin
         pend_letter  = v;
         pend_valid   = 1'b1;
         pend_decrypt = dec;
         return 1'b0;
      end
      // Mode change closes the held letter with the pad
      if (pend_decrypt != dec) begin
         res          = substitute(pend_letter, pad_choice(), pend_decrypt);
         pend_letter  = v;
         pend_decrypt = dec;
         return 1'b1;
      end
      // Doubled encrypt letter takes the pad and stays held
      if (!dec && pend_letter == v) begin
         res = substitute(pend_letter, pad_choice(), 1'b0);
         return 1'b1;
      end
      res        = substitute(pend_letter, v, dec);
      pend_valid = 1'b0;
      return 1'b1;
   endfunction

   function automatic void row_open(input mode_type m, input logic [LETTER_W-1:0] l);
      stim_row_type r;
      r.item.mode   = m;
      r.item.letter = l;
      r.fixed_on    = 1'b0;
      r.fixed       = '0;
      directed_rows.push_back(r);
   endfunction

   function automatic void row_fixed(input mode_type m, input logic [LETTER_W-1:0] l,
                                     input logic [LETTER_W-1:0] pf,
                                     input logic [LETTER_W-1:0] ps,
                                     input logic [LETTER_W-1:0] of,
                                     input logic [LETTER_W-1:0] os);
      stim_row_type r;
      r.item.mode   = m;
      r.item.letter = l;
      r.fixed_on    = 1'b1;
      r.fixed       = '{plain_first: pf, plain_second: ps, out_first: of, out_second: os};
      directed_rows.push_back(r);
   endfunction

   // Draw the next random transaction: key bursts, text runs, ends and noise
   function automatic req_item_type next_random_item();
      req_item_type it;
      int           pick;
      if (key_left > 0) begin
         key_left--;
         it.mode   = MODE_KEY;
         it.letter = LETTER_W'($urandom_range(0, NUM_LETTERS - 1));
         return it;
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         key_left  = $urandom_range(0, 9);
         it.mode   = MODE_KEY;
         it.letter = LETTER_W'($urandom_range(0, NUM_LETTERS - 1));
      end else if (pick < 9) begin
         it.mode   = MODE_END;
         it.letter = LETTER_W'($urandom);
      end else if (pick < 13) begin
         it.mode   = mode_type'($urandom_range(0, 3));
         it.letter = LETTER_W'($urandom_range(NUM_LETTERS, 31));
      end else begin
         if (pick < 20) begin
            text_mode = (text_mode == MODE_ENCRYPT) ? MODE_DECRYPT : MODE_ENCRYPT;
         end
         it.mode   = text_mode;
         it.letter = (pick < 32) ? last_text : LETTER_W'($urandom_range(0, NUM_LETTERS - 1));
         last_text = it.letter;
      end
      return it;
   endfunction

   // Offer one transaction after a random gap and record its prediction
   task automatic send_transaction(input req_item_type it, input bit fixed_on,
                                   input rsp_item_type fixed);
      int           gap;
      rsp_item_type predicted;
      gap = tx_quiet ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (cipher_step(it, predicted)) begin
         expected_digraphs.push_back(fixed_on ? fixed : predicted);
      end
   endtask

   // Hold the input idle until every digraph has come out, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_digraphs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the pad letter register through a setup and an access cycle
   task automatic write_pad(input logic [LETTER_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PAD_ADDR;
      pwdata  <= {(CSR_DATA_W - LETTER_W)'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      pad_reg = value;
   endtask

   task automatic note_mismatch(input string what, input rsp_item_type want,
                                input rsp_item_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("mismatch (%s): expected %0d %0d -> %0d %0d, got %0d %0d -> %0d %0d",
                  what, want.plain_first, want.plain_second, want.out_first,
                  want.out_second, got.plain_first, got.plain_second, got.out_first,
                  got.out_second);
      end
   endtask

   // Check each result transaction and pace rsp_ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_digraphs.size() == 0) begin
               note_mismatch("unexpected", '0, rsp_item);
            end else begin
               next_digraph = expected_digraphs.pop_front();
               if (next_digraph.plain_first != rsp_item.plain_first ||
                   next_digraph.plain_second != rsp_item.plain_second ||
                   next_digraph.out_first != rsp_item.out_first ||
                   next_digraph.out_second != rsp_item.out_second) begin
                  note_mismatch("digraph", next_digraph, rsp_item);
               end
            end
            rx_wait = rx_quiet ? 0 : $urandom_range(0, 12);
         end
         if (rx_hold) begin
            rsp_ready <= 1'b0;
         end else if (rx_wait > 0) begin
            rx_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Stall the result side for a long stretch while the sender keeps going
   initial begin
      wait (hold_armed);
      repeat (30) @(posedge clock);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rx_hold <= 1'b0;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      req_item_type        it;
      int                  count;
      logic [LETTER_W-1:0] pad_value;
      clear_key_grid();
      pad_reg        = PAD_RESET;
      text_mode      = MODE_ENCRYPT;
      last_text      = LT_A;
      key_left       = 0;
      tx_quiet       = 1'b0;
      rx_quiet       = 1'b0;
      hold_armed     = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default grid after reset, pad X: row, doubled letter, column, decrypt column
      row_open (MODE_ENCRYPT, LT_A);
      row_fixed(MODE_ENCRYPT, LT_B, LT_A, LT_B, LT_B, LT_C);
      row_open (MODE_ENCRYPT, LT_A);
      row_fixed(MODE_ENCRYPT, LT_A, LT_A, LT_X, LT_C, LT_V);
      row_fixed(MODE_ENCRYPT, LT_F, LT_A, LT_F, LT_F, LT_L);
      row_open (MODE_DECRYPT, LT_Z);
      row_fixed(MODE_DECRYPT, LT_E, LT_Z, LT_E, LT_U, LT_Z);
      // Letters out of range are ignored, also as key letters after text
      row_open (MODE_ENCRYPT, 5'd31);
      row_open (MODE_DECRYPT, 5'd26);
      row_open (MODE_KEY, 5'd30);
      // J folds onto I
      row_open (MODE_ENCRYPT, LT_J);
      row_fixed(MODE_ENCRYPT, LT_K, LT_I, LT_K, LT_K, LT_F);
      // Mode change closes the held letter, end closes it in its own mode
      row_open (MODE_ENCRYPT, LT_B);
      row_fixed(MODE_DECRYPT, LT_C, LT_B, LT_X, LT_C, LT_W);
      row_fixed(MODE_END, 5'd31, LT_C, LT_X, LT_X, LT_S);
      row_open (MODE_END, LT_A);
      // Doubled pad letter
      row_open (MODE_ENCRYPT, LT_X);
      row_fixed(MODE_ENCRYPT, LT_X, LT_X, LT_X, LT_Y, LT_Y);
      row_fixed(MODE_END, LT_A, LT_X, LT_X, LT_Y, LT_Y);
      // Fresh key after text, with J folded and duplicates dropped
      row_open (MODE_KEY, LT_Z);
      row_open (MODE_KEY, LT_J);
      row_open (MODE_KEY, LT_I);
      row_open (MODE_KEY, LT_A);
      row_open (MODE_ENCRYPT, LT_Z);
      row_open (MODE_DECRYPT, LT_Y);
      row_open (MODE_END, LT_Z);

      foreach (directed_rows[n]) begin
         send_transaction(directed_rows[n].item, directed_rows[n].fixed_on,
                          directed_rows[n].fixed);
      end

      // Random phases, each under its own pad letter
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_idle();
         case (phase)
            0:       pad_value = 5'd0;
            1:       pad_value = 5'd31;
            3:       pad_value = LAST_LETTER;
            4:       pad_value = LETTER_J;
            5:       pad_value = 5'd26;
            7:       pad_value = PAD_RESET;
            default: pad_value = LETTER_W'($urandom);
         endcase
         write_pad(pad_value);
         tx_quiet = (phase == 1 || phase == 4);
         rx_quiet = (phase == 1 || phase == 5);
         if (phase == 2) begin
            hold_armed = 1'b1;
         end
         count = 0;
         while (count < ITEMS_PER_PHASE) begin
            it = next_random_item();
            send_transaction(it, 1'b0, '0);
            if (it.mode == MODE_END || it.letter < NUM_LETTERS) begin
               count++;
            end
         end
      end

      wait_idle();
      if (mismatch_count == 0 && expected_digraphs.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
